>>> sv/rc4sc_pkg.sv
// Shared types and constants for the RC4 stream cipher unit.
`default_nettype none

package rc4sc_pkg;

   localparam int BYTE_W        = 8;
   localparam int PERM_DEPTH    = 256;
   localparam int COUNT_W       = 9;
   localparam int KEY_DEPTH_DEF = 256;

   localparam logic ACT_KEY  = 1'b0;
   localparam logic ACT_DATA = 1'b1;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] data_byte;
      logic              key_last;
      logic              restart;
   } rc4sc_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [BYTE_W-1:0] keystream_byte;
   } rc4sc_rsp_type;

endpackage

`default_nettype wire

>>> sv/rc4_stream_cipher_unit.sv
// Top level of the RC4 stream cipher unit: key loading, key schedule and keystream.
`default_nettype none

// RC4 stream cipher. Each request word is either a key byte (action = 0) or a data byte
// (action = 1). Key bytes are held in a key store, up to KEY_DEPTH of them; further
// bytes are dropped, and the word flagged key_last starts the key schedule over the
// 256-entry permutation using the stored bytes repeated cyclically. A data word runs one
// keystream step and returns one response word carrying the data byte XOR the keystream
// byte, plus the keystream byte itself; key words return nothing. Setting restart on a
// data word zeroes both stream indices first, while the permutation carries over. The
// permutation lives in one 256 x 8 synchronous RAM with one read and one write port,
// and that single port pair sets the order of a data word (read S[i], read S[j],
// write S[i] while reading S[S[i]+S[j]], write S[j], held there until the output
// register is free), with the keystream byte forwarded from the swap when its address
// hits i or j. A final key word first runs a sweep that restores the identity
// permutation, then each schedule step reads two entries and writes two. After reset
// the same identity sweep runs before the first word is taken. req_stall is high
// whenever the unit is busy; a finished response waits in the output register, so a
// new request is taken while the previous response is still stalled.
module rc4_stream_cipher_unit #(
   parameter int KEY_DEPTH = rc4sc_pkg::KEY_DEPTH_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  rc4sc_pkg::rc4sc_req_type req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output rc4sc_pkg::rc4sc_rsp_type rsp_data
);
   import rc4sc_pkg::*;

   localparam int KeyAw = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   typedef enum logic [9:0] {
      ST_INIT       = 10'b00_0000_0001,
      ST_IDLE       = 10'b00_0000_0010,
      ST_RD_J       = 10'b00_0000_0100,
      ST_WR_I       = 10'b00_0000_1000,
      ST_WR_J       = 10'b00_0001_0000,
      ST_SC_RD_K    = 10'b00_0010_0000,
      ST_SC_RD_ACC  = 10'b00_0100_0000,
      ST_SC_WR_K    = 10'b00_1000_0000,
      ST_SC_WR_ACC  = 10'b01_0000_0000,
      ST_SPARE      = 10'b10_0000_0000
   } state_type;

   // Permutation RAM and key store
   logic [BYTE_W-1:0] perm_mem [PERM_DEPTH];
   logic [BYTE_W-1:0] key_mem  [KEY_DEPTH];

   logic              perm_we;
   logic [BYTE_W-1:0] perm_wa;
   logic [BYTE_W-1:0] perm_wd;
   logic              perm_re;
   logic [BYTE_W-1:0] perm_ra;
   logic [BYTE_W-1:0] perm_rd_ff;

   logic              key_we;
   logic [BYTE_W-1:0] key_rd_ff;

   // Control and datapath registers
   state_type          state_ff, state_in;
   logic               sched_ff, sched_in;
   logic [COUNT_W-1:0] key_count_ff, key_count_in;
   logic [BYTE_W-1:0]  idx_i_ff, idx_i_in;
   logic [BYTE_W-1:0]  idx_j_ff, idx_j_in;
   logic [BYTE_W-1:0]  k_ff, k_in;
   logic [BYTE_W-1:0]  acc_ff, acc_in;
   logic [BYTE_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0]  si_ff, si_in;
   logic [BYTE_W-1:0]  sj_ff, sj_in;
   logic [BYTE_W-1:0]  t_ff, t_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rc4sc_rsp_type      rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic               rsp_free;
   logic               key_room;
   logic [BYTE_W-1:0]  acc_sum;
   logic [BYTE_W-1:0]  ks_byte;
   logic [COUNT_W-1:0] pos_plus;
   logic [BYTE_W-1:0]  i_base;
   logic [BYTE_W-1:0]  j_base;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign key_room  = (key_count_ff < COUNT_W'(KEY_DEPTH));
   assign key_we    = req_take && (req_data.action == ACT_KEY) && key_room;
   assign acc_sum   = acc_ff + perm_rd_ff + key_rd_ff;
   assign pos_plus  = {1'b0, pos_ff} + COUNT_W'(1);
   assign i_base    = req_data.restart ? '0 : idx_i_ff;
   assign j_base    = req_data.restart ? '0 : idx_j_ff;

   // Keystream byte: j was written last, so a hit on j wins over a hit on i
   always_comb begin
      priority if (t_ff == idx_j_ff) begin
         ks_byte = si_ff;
      end else if (t_ff == idx_i_ff) begin
         ks_byte = sj_ff;
      end else begin
         ks_byte = perm_rd_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sched_in     = sched_ff;
      key_count_in = key_count_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      perm_we      = 1'b0;
      perm_wa      = k_ff;
      perm_wd      = k_ff;
      perm_re      = 1'b0;
      perm_ra      = k_ff;

      unique case (state_ff)
         ST_INIT: begin
            // Restore the identity permutation, one entry a cycle
            perm_we = 1'b1;
            perm_wa = k_ff;
            perm_wd = k_ff;
            k_in    = k_ff + BYTE_W'(1);
            if (k_ff == '1) begin
               acc_in   = '0;
               pos_in   = '0;
               sched_in = 1'b0;
               state_in = sched_ff ? ST_SC_RD_K : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.action == ACT_KEY) begin
                  if (key_room) begin
                     key_count_in = key_count_ff + COUNT_W'(1);
                  end
                  if (req_data.key_last) begin
                     sched_in = 1'b1;
                     k_in     = '0;
                     state_in = ST_INIT;
                  end
               end else begin
                  // Advance i and fetch S[i]
                  idx_i_in = i_base + BYTE_W'(1);
                  idx_j_in = j_base;
                  byte_in  = req_data.data_byte;
                  perm_re  = 1'b1;
                  perm_ra  = i_base + BYTE_W'(1);
                  state_in = ST_RD_J;
               end
            end
         end
         ST_RD_J: begin
            si_in    = perm_rd_ff;
            idx_j_in = idx_j_ff + perm_rd_ff;
            perm_re  = 1'b1;
            perm_ra  = idx_j_ff + perm_rd_ff;
            state_in = ST_WR_I;
         end
         ST_WR_I: begin
            sj_in    = perm_rd_ff;
            perm_we  = 1'b1;
            perm_wa  = idx_i_ff;
            perm_wd  = perm_rd_ff;
            perm_re  = 1'b1;
            perm_ra  = si_ff + perm_rd_ff;
            t_in     = si_ff + perm_rd_ff;
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            // Hold here until the output register frees up
            perm_we = 1'b1;
            perm_wa = idx_j_ff;
            perm_wd = si_ff;
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.out_byte        = byte_ff ^ ks_byte;
               rsp_data_in.keystream_byte  = ks_byte;
               state_in                    = ST_IDLE;
            end
         end
         ST_SC_RD_K: begin
            perm_re  = 1'b1;
            perm_ra  = k_ff;
            state_in = ST_SC_RD_ACC;
         end
         ST_SC_RD_ACC: begin
            si_in    = perm_rd_ff;
            acc_in   = acc_sum;
            perm_re  = 1'b1;
            perm_ra  = acc_sum;
            state_in = ST_SC_WR_K;
         end
         ST_SC_WR_K: begin
            perm_we  = 1'b1;
            perm_wa  = k_ff;
            perm_wd  = perm_rd_ff;
            state_in = ST_SC_WR_ACC;
         end
         ST_SC_WR_ACC: begin
            perm_we = 1'b1;
            perm_wa = acc_ff;
            perm_wd = si_ff;
            k_in    = k_ff + BYTE_W'(1);
            // Wrap the key position at the key length
            pos_in  = (pos_plus >= key_count_ff) ? '0 : pos_ff + BYTE_W'(1);
            if (k_ff == '1) begin
               key_count_in = '0;
               idx_i_in     = '0;
               idx_j_in     = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SC_RD_K;
            end
         end
         ST_SPARE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sched_ff     <= 1'b0;
         key_count_ff <= '0;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sched_ff     <= sched_in;
         key_count_ff <= key_count_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      pos_ff      <= pos_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Permutation RAM: read data held unless a read is issued
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_wa] <= perm_wd;
      end
      if (perm_re) begin
         perm_rd_ff <= perm_mem[perm_ra];
      end
   end

   // Key store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_count_ff[KeyAw-1:0]] <= req_data.data_byte;
      end
      key_rd_ff <= key_mem[pos_ff[KeyAw-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the RC4 stream cipher unit: scripted and random words.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rc4sc_pkg::*;

   localparam int STORE_DEPTH    = KEY_DEPTH_DEF;
   localparam int SCRIPT_ROWS    = 21;
   localparam int RANDOM_WORDS   = 750;
   // A final key word keeps the unit busy through the identity sweep and the key
   // schedule, with no request taken; leave plenty of room above that for stall streaks.
   localparam int WATCHDOG_LIMIT = 20000;
   // One full key schedule, so a stray response from a late schedule still shows up.
   localparam int DRAIN_CYCLES   = 1300;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   rc4sc_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rc4sc_rsp_type rsp_data;

   rc4_stream_cipher_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10ns clock = ~clock;

   // One scripted word: the request, whether its response is typed in here, and that
   // response. Rows without a typed response are checked against the shadow cipher.
   typedef struct packed {
      rc4sc_req_type word;
      logic          typed;
      rc4sc_rsp_type want;
   } script_row_type;

   // Fields per row: action, byte, key_last, restart, typed, out_byte, keystream_byte.
   script_row_type opening_script [0:SCRIPT_ROWS-1] = '{
      // Data on the reset permutation: i = 1, j = 1, keystream S[2] = 2.
      {ACT_DATA, 8'h00, 1'b0, 1'b0, 1'b1, 8'h02, 8'h02},
      // i = 2, j = 3, swap, keystream S[5] = 5; key_last has no effect on data.
      {ACT_DATA, 8'hff, 1'b1, 1'b0, 1'b1, 8'hfa, 8'h05},
      // Restart mid-stream: indices zeroed, permutation kept.
      {ACT_DATA, 8'ha5, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h5a, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
      // Two-byte key at the byte extremes; restart means nothing on a key word.
      {ACT_KEY,  8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_KEY,  8'hff, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'hff, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
      // Single-byte key; the schedule also zeroes the indices.
      {ACT_KEY,  8'h80, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h7f, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h80, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      // Four-byte key.
      {ACT_KEY,  8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_KEY,  8'h02, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_KEY,  8'hfe, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_KEY,  8'h7f, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'hff, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h55, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'haa, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
      {ACT_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}
   };

   // Shadow copy of the cipher state.
   logic [7:0] shadow_perm [0:255];
   logic [7:0] shadow_key  [0:255];
   logic [8:0] shadow_key_len;
   logic [7:0] shadow_i;
   logic [7:0] shadow_j;

   rc4sc_rsp_type pending_cipher_out [$];
   logic          script_typed;
   rc4sc_rsp_type script_want;
   int            mismatches   = 0;
   int            words_sent   = 0;
   int            quiet_cycles = 0;
   bit            calm         = 1'b0;

   initial begin
      for (int k = 0; k < 256; k++) begin
         shadow_perm[k] = 8'(k);
         shadow_key[k]  = 8'h00;
      end
      shadow_key_len = '0;
      shadow_i       = '0;
      shadow_j       = '0;
   end

   // Advance the shadow cipher by one accepted word; a data word yields its output.
   function automatic void shadow_step(input rc4sc_req_type w, output bit emits,
                                       output rc4sc_rsp_type res);
      logic [7:0] si, sj, sum, acc, swap;
      int         pos;
      int         span;
      emits = 1'b0;
      res   = '0;
      if (w.action == ACT_KEY) begin
         // Saturate: bytes past the store depth are dropped.
         if (shadow_key_len < STORE_DEPTH) begin
            shadow_key[shadow_key_len[7:0]] = w.data_byte;
            shadow_key_len = shadow_key_len + 9'd1;
         end
         if (w.key_last) begin
            span = (shadow_key_len == 0) ? 1 : int'(shadow_key_len);
            for (int k = 0; k < 256; k++) shadow_perm[k] = 8'(k);
            acc = '0;
            pos = 0;
            for (int k = 0; k < 256; k++) begin
               acc  = acc + shadow_perm[k] + shadow_key[pos];
               swap = shadow_perm[k];
               shadow_perm[k]   = shadow_perm[acc];
               shadow_perm[acc] = swap;
               pos = (pos + 1 >= span) ? 0 : pos + 1;
            end
            shadow_key_len = '0;
            shadow_i       = '0;
            shadow_j       = '0;
         end
      end else begin
         if (w.restart) begin
            shadow_i = '0;
            shadow_j = '0;
         end
         shadow_i = shadow_i + 8'd1;
         shadow_j = shadow_j + shadow_perm[shadow_i];
         si = shadow_perm[shadow_i];
         sj = shadow_perm[shadow_j];
         shadow_perm[shadow_i] = sj;
         shadow_perm[shadow_j] = si;
         sum = si + sj;
         res.keystream_byte = shadow_perm[sum];
         res.out_byte       = w.data_byte ^ res.keystream_byte;
         emits = 1'b1;
      end
   endfunction

   // Idle on roughly 28 rolls in a hundred, except during the calm stretch.
   function automatic bit idle_roll();
      return !calm && ($urandom_range(0, 99) < 28);
   endfunction

   // Stall the response side at random from the very first cycle.
   always @(posedge clock) rsp_stall <= idle_roll();

   // Sample both channels on the pre-edge values: predict on every accepted request
   // word, check every accepted response word, and watch for a hung unit.
   always @(posedge clock) begin
      bit            emits;
      rc4sc_rsp_type res;
      rc4sc_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            shadow_step(req_data, emits, res);
            // A typed-in response takes the place of the prediction.
            if (emits) pending_cipher_out.push_back(script_typed ? script_want : res);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_cipher_out.size() == 0) begin
               $error("unexpected word: out_byte %h, keystream_byte %h",
                      rsp_data.out_byte, rsp_data.keystream_byte);
               mismatches++;
            end else begin
               want = pending_cipher_out.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  mismatches++;
               end
               if (rsp_data.keystream_byte !== want.keystream_byte) begin
                  $error("keystream_byte: expected %h, got %h",
                         want.keystream_byte, rsp_data.keystream_byte);
                  mismatches++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   // Present one word, idling first at random, and hold it until it is taken.
   task automatic send_word(input rc4sc_req_type w, input bit typed,
                            input rc4sc_rsp_type want);
      while (idle_roll()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_data     <= w;
      script_typed <= typed;
      script_want  <= want;
      do @(posedge clock); while (req_stall);
      words_sent++;
      // Drop all idling for a stretch in the middle of the random part.
      calm = (words_sent >= 330 && words_sent < 470);
   endtask

   // Load a key of the given length; the last byte starts the schedule.
   task automatic send_key(input int len);
      rc4sc_req_type w;
      for (int k = 0; k < len; k++) begin
         w.action    = ACT_KEY;
         w.data_byte = 8'($urandom);
         w.key_last  = (k == len - 1);
         w.restart   = 1'($urandom);
         send_word(w, 1'b0, '0);
      end
   endtask

   // Send one message: restart on the first byte, occasionally again inside it.
   task automatic send_message(input int len);
      rc4sc_req_type w;
      for (int k = 0; k < len; k++) begin
         w.action    = ACT_DATA;
         w.data_byte = 8'($urandom);
         w.key_last  = 1'($urandom);
         w.restart   = (k == 0) || ($urandom_range(0, 15) == 0);
         send_word(w, 1'b0, '0);
      end
   endtask

   initial begin
      rc4sc_req_type w;
      int            pick;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      script_typed = 1'b0;
      script_want  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Scripted opening: data before any key, flag extremes, short keys.
      for (int r = 0; r < SCRIPT_ROWS; r++)
         send_word(opening_script[r].word, opening_script[r].typed, opening_script[r].want);

      // Overlong key first, so saturation of the key store is always reached.
      send_key(STORE_DEPTH + $urandom_range(1, 6));
      send_message($urandom_range(1, 24));

      // Mostly well-formed key and message sequences, with some raw noise words.
      while (words_sent < SCRIPT_ROWS + RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            w.action    = 1'($urandom);
            w.data_byte = 8'($urandom);
            w.key_last  = 1'($urandom);
            w.restart   = 1'($urandom);
            send_word(w, 1'b0, '0);
         end else if (pick < 40) begin
            if ($urandom_range(0, 29) == 0) send_key($urandom_range(250, 262));
            else send_key($urandom_range(1, 16));
            send_message($urandom_range(1, 24));
         end else begin
            send_message($urandom_range(1, 24));
         end
      end
      req_valid <= 1'b0;

      // Drain, then give a late schedule time to show any stray response.
      while (pending_cipher_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_cipher_out.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
